// ===== sv/cdtf_pkg.sv =====
// Shared types, constants and helpers for the call-depth trace filter.
package cdtf_pkg;

  // Stack geometry
  localparam int STACK_LEVELS = 1024;
  localparam int LEVEL_IN_W   = 10;
  localparam int LEVEL_W      = $clog2(STACK_LEVELS);

  // Field and counter widths
  localparam int BUDGET_W = 10;
  localparam int COUNT_W  = 11;
  localparam logic [COUNT_W-1:0]  COUNT_MAX    = '1;
  localparam logic [BUDGET_W-1:0] BUDGET_RESET = 10'd1023;

  // Decoupling queues (power of two)
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 10;
  localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_BUDGET = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_INCLUDE_MODE   = 1'b1;

  // Event kinds
  localparam logic CMD_ENTRY = 1'b0;
  localparam logic CMD_EXIT  = 1'b1;

  // Level reduction by reciprocal multiply
  localparam int DIV_SHIFT = 20;
  localparam logic [20:0] LEVEL_RECIP = 21'((2 ** DIV_SHIFT) / STACK_LEVELS);

  typedef struct packed {
    logic                  cmd;
    logic [LEVEL_IN_W-1:0] level;
    logic                  filter_hit;
    logic                  filter_exclude;
    logic                  depth_trigger;
    logic [BUDGET_W-1:0]   trigger_depth;
    logic                  trace_on;
    logic                  trace_off;
  } trace_evt_t;

  typedef struct packed {
    logic                emit;
    logic                no_record;
    logic [BUDGET_W-1:0] depth_left;
  } verdict_t;

  typedef struct packed {
    logic never_record;
    logic notrace;
    logic filtered;
  } marks_t;

  typedef struct packed {
    marks_t              marks;
    logic [BUDGET_W-1:0] saved;
  } stack_entry_t;

  // Classified event handed from front to back
  typedef struct packed {
    logic                is_exit;
    logic [LEVEL_W-1:0]  slot;
    logic                include_hit;
    logic                exclude_hit;
    logic                depth_trigger;
    logic [BUDGET_W-1:0] trigger_depth;
    logic                trace_on;
    logic                trace_off;
  } op_t;

  typedef struct packed {
    logic [BUDGET_W-1:0] default_budget;
    logic                include_mode;
  } cfg_t;

  localparam stack_entry_t CLEAR_ENTRY = '{marks: '0, saved: BUDGET_RESET};

  // level modulo STACK_LEVELS: reciprocal estimate is low by at most one
  function automatic logic [LEVEL_W-1:0] level_slot(input logic [LEVEL_IN_W-1:0] level);
    logic [31:0]           prod;
    logic [LEVEL_IN_W-1:0] quo;
    logic [23:0]           rem;
    prod = 32'(level) * 32'(LEVEL_RECIP);
    quo  = LEVEL_IN_W'(prod >> DIV_SHIFT);
    rem  = 24'(level) - 24'(quo) * 24'(STACK_LEVELS);
    if (rem >= 24'(STACK_LEVELS)) begin
      rem = rem - 24'(STACK_LEVELS);
    end
    if (STACK_LEVELS >= (2 ** LEVEL_IN_W)) begin
      rem = 24'(level);
    end
    return LEVEL_W'(rem);
  endfunction

endpackage

// ===== sv/call_depth_trace_filter_unit.sv =====
// Top level of the call-depth trace filter: config registers, front end, back end, result queue.
// Trace events go in through a queue interface (push/full) and one verdict per event comes out
// through another (empty/pop). The unit sustains one event per clock while the result queue has
// room: the stack RAM is read when an event leaves the front queue and written in the following
// cycle by the execute stage, with the previous write forwarded, so the read-execute-write loop
// over the per-level stack sets the rate. A verdict is registered in the execute stage and then
// held in the result queue, where it waits while the result side stalls. After reset a clearing
// pass writes every stack level, during which full stays high; configuration writes take effect
// at once and are meant to be made while no event is in flight.
module call_depth_trace_filter_unit import cdtf_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  output logic                  full,
  input  trace_evt_t            trace_evt,
  output logic                  empty,
  input  logic                  pop,
  output verdict_t              verdict,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t              cfg;
  logic              op_valid;
  op_t               op;
  logic              op_pop;
  logic              res_push;
  verdict_t          res;
  logic [QCNT_W-1:0] res_fill;
  logic              clearing;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.default_budget <= BUDGET_RESET;
      cfg.include_mode   <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_DEFAULT_BUDGET: cfg.default_budget <= cfg_data[BUDGET_W-1:0];
        REG_INCLUDE_MODE:   cfg.include_mode   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  cdtf_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .trace_evt (trace_evt),
    .busy      (clearing),
    .op_valid  (op_valid),
    .op        (op),
    .op_pop    (op_pop)
  );

  cdtf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .op_valid  (op_valid),
    .op        (op),
    .op_pop    (op_pop),
    .res_fill  (res_fill),
    .res_push  (res_push),
    .res       (res),
    .clearing  (clearing)
  );

  cdtf_outq u_outq (
    .clk      (clk),
    .rst      (rst),
    .res_push (res_push),
    .res      (res),
    .pop      (pop),
    .empty    (empty),
    .verdict  (verdict),
    .count    (res_fill)
  );

  // Back end never pushes a verdict into a full result queue
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    res_push |-> (res_fill != QCNT_W'(QUEUE_DEPTH) || (pop && !empty)))
    else $error("result queue overflow");

  // Nothing issues to the stack while it is being cleared
  a_no_issue_clear: assert property (@(posedge clk) disable iff (rst)
    clearing |-> (!op_pop && !res_push && full))
    else $error("event issued during clearing pass");

  // An issued event reaches the result queue on the next cycle
  a_issue_push: assert property (@(posedge clk) disable iff (rst)
    op_pop |=> res_push)
    else $error("issued event produced no verdict");

endmodule

// ===== sv/cdtf_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module cdtf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/cdtf_front.sv =====
// Front end: accepts trace events, classifies them and queues them for the back end.
module cdtf_front import cdtf_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  trace_evt_t trace_evt,
  input  logic       busy,
  output logic       op_valid,
  output op_t        op,
  input  logic       op_pop
);

  op_t               slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              accept;
  op_t               op_in;

  // Classify the incoming event
  always_comb begin
    op_in.is_exit       = (trace_evt.cmd == CMD_EXIT);
    op_in.slot          = level_slot(trace_evt.level);
    op_in.include_hit   = trace_evt.filter_hit & ~trace_evt.filter_exclude;
    op_in.exclude_hit   = trace_evt.filter_hit & trace_evt.filter_exclude;
    op_in.depth_trigger = trace_evt.depth_trigger;
    op_in.trigger_depth = trace_evt.trigger_depth;
    op_in.trace_on      = trace_evt.trace_on;
    op_in.trace_off     = trace_evt.trace_off;
  end

  // No transaction while the stack is being cleared
  assign full     = (count == QCNT_W'(QUEUE_DEPTH)) || busy;
  assign accept   = push && !full;
  assign op_valid = (count != '0);
  assign op       = slots[rd_ptr];

  // Queue storage
  always_ff @(posedge clk) begin
    if (accept) begin
      slots[wr_ptr] <= op_in;
    end
  end

  // Queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (accept) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (op_pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      count <= count + QCNT_W'(accept) - QCNT_W'(op_pop);
    end
  end

endmodule

// ===== sv/cdtf_back.sv =====
// Back end: per-level stack, open-filter counts, budget and tracing state.
module cdtf_back import cdtf_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  cfg_t              cfg,
  input  logic              op_valid,
  input  op_t               op,
  output logic              op_pop,
  input  logic [QCNT_W-1:0] res_fill,
  output logic              res_push,
  output verdict_t          res,
  output logic              clearing
);

  localparam int SW = $bits(stack_entry_t);

  // Clearing pass
  logic [LEVEL_W-1:0] clr_addr;

  // Execute stage
  logic b_valid;
  op_t  b_op;

  // Last write, for read-during-write forwarding
  logic               last_valid;
  logic [LEVEL_W-1:0] last_addr;
  stack_entry_t       last_data;

  // Architectural state
  logic [COUNT_W-1:0]  include_open, include_open_next;
  logic [COUNT_W-1:0]  exclude_open, exclude_open_next;
  logic [BUDGET_W-1:0] depth_budget, depth_budget_next;
  logic                tracing_on, tracing_on_next;

  // RAM side
  logic               ram_we;
  logic [LEVEL_W-1:0] ram_waddr;
  stack_entry_t       ram_wdata;
  logic [SW-1:0]      ram_rdata;
  stack_entry_t       stored;
  stack_entry_t       wr_entry;

  // Execute scratch
  marks_t              marks;
  logic                go;
  logic                emit;
  logic                norec;
  logic [QCNT_W:0]     in_flight;

  cdtf_ram #(
    .WIDTH (SW),
    .DEPTH (STACK_LEVELS)
  ) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (op.slot),
    .rdata (ram_rdata)
  );

  // Issue only when the result queue is sure to have room
  assign in_flight = {1'b0, res_fill} + (QCNT_W + 1)'(b_valid);
  assign op_pop    = op_valid && !clearing && (in_flight < (QCNT_W + 1)'(QUEUE_DEPTH));

  assign ram_we    = clearing || b_valid;
  assign ram_waddr = clearing ? clr_addr : b_op.slot;
  assign ram_wdata = clearing ? CLEAR_ENTRY : wr_entry;

  // Stack read with forwarding of the previous cycle's write
  assign stored = (last_valid && last_addr == b_op.slot) ? last_data
                                                         : stack_entry_t'(ram_rdata);

  // Event execution
  always_comb begin
    include_open_next = include_open;
    exclude_open_next = exclude_open;
    depth_budget_next = depth_budget;
    tracing_on_next   = tracing_on;
    marks             = '0;
    go                = 1'b0;
    emit              = 1'b0;
    norec             = 1'b0;
    wr_entry.marks    = '0;
    wr_entry.saved    = depth_budget;
    if (b_op.is_exit) begin
      if (stored.marks.filtered) begin
        if (include_open != '0) begin
          include_open_next = include_open - COUNT_W'(1);
        end
      end else if (stored.marks.notrace) begin
        if (exclude_open != '0) begin
          exclude_open_next = exclude_open - COUNT_W'(1);
        end
      end
      norec             = stored.marks.never_record;
      depth_budget_next = stored.saved;
      wr_entry.saved    = stored.saved;
    end else begin
      if (exclude_open != '0) begin
        marks.never_record = 1'b1;
      end else if (b_op.include_hit) begin
        if (include_open != COUNT_MAX) begin
          include_open_next = include_open + COUNT_W'(1);
        end
        marks.filtered    = 1'b1;
        depth_budget_next = cfg.default_budget;
        go                = 1'b1;
      end else if (b_op.exclude_hit) begin
        if (exclude_open != COUNT_MAX) begin
          exclude_open_next = exclude_open + COUNT_W'(1);
        end
        marks.notrace      = 1'b1;
        marks.never_record = 1'b1;
      end else if (cfg.include_mode && include_open == '0) begin
        marks.never_record = 1'b1;
      end else begin
        go = 1'b1;
      end
      if (go) begin
        if (b_op.depth_trigger) begin
          depth_budget_next = b_op.trigger_depth;
        end
        if (b_op.trace_on) begin
          tracing_on_next = 1'b1;
        end
        if (b_op.trace_off) begin
          tracing_on_next = 1'b0;
        end
        // tracing off: skipped but not marked
        if (tracing_on_next) begin
          if (depth_budget_next == '0) begin
            marks.never_record = 1'b1;
          end else begin
            depth_budget_next = depth_budget_next - BUDGET_W'(1);
            emit              = 1'b1;
          end
        end
      end
      norec          = marks.never_record;
      wr_entry.marks = marks;
    end
  end

  assign res_push       = b_valid;
  assign res.emit       = emit;
  assign res.no_record  = norec;
  assign res.depth_left = depth_budget_next;

  // Payload registers
  always_ff @(posedge clk) begin
    if (op_pop) begin
      b_op <= op;
    end
    last_addr <= b_op.slot;
    last_data <= wr_entry;
  end

  // Control and state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing     <= 1'b1;
      clr_addr     <= '0;
      b_valid      <= 1'b0;
      last_valid   <= 1'b0;
      include_open <= '0;
      exclude_open <= '0;
      depth_budget <= BUDGET_RESET;
      tracing_on   <= 1'b1;
    end else begin
      if (clearing) begin
        clr_addr <= clr_addr + LEVEL_W'(1);
        if (clr_addr == LEVEL_W'(STACK_LEVELS - 1)) begin
          clearing <= 1'b0;
        end
      end
      b_valid    <= op_pop;
      last_valid <= b_valid;
      if (b_valid) begin
        include_open <= include_open_next;
        exclude_open <= exclude_open_next;
        depth_budget <= depth_budget_next;
        tracing_on   <= tracing_on_next;
      end
    end
  end

endmodule

// ===== sv/cdtf_outq.sv =====
// Result queue between the back end and the result ports.
module cdtf_outq import cdtf_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              res_push,
  input  verdict_t          res,
  input  logic              pop,
  output logic              empty,
  output verdict_t          verdict,
  output logic [QCNT_W-1:0] count
);

  verdict_t          slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic              take;

  assign empty   = (count == '0);
  assign take    = pop && !empty;
  assign verdict = slots[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (res_push) begin
      slots[wr_ptr] <= res;
    end
  end

  // Pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (res_push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (take) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      count <= count + QCNT_W'(res_push) - QCNT_W'(take);
    end
  end

endmodule

// ===== verif/tb.sv =====
// Testbench for call_depth_trace_filter_unit: random and directed event streams checked against a predictor.
`timescale 1ns / 100ps

module tb;
  import cdtf_pkg::*;

  logic clk = 1'b0;
  logic rst;

  logic                  push;
  logic                  full;
  trace_evt_t            trace_evt;
  logic                  empty;
  logic                  pop;
  verdict_t              verdict;
  logic                  cfg_write;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  call_depth_trace_filter_unit dut (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .trace_evt (trace_evt),
    .empty     (empty),
    .pop       (pop),
    .verdict   (verdict),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Clock: 10 ns period
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state
  logic [BUDGET_W-1:0] cfg_budget;
  logic                cfg_incl_mode;
  marks_t              lvl_mark [STACK_LEVELS];
  logic [BUDGET_W-1:0] lvl_saved [STACK_LEVELS];
  logic [COUNT_W-1:0]  incl_open;
  logic [COUNT_W-1:0]  excl_open;
  logic [BUDGET_W-1:0] budget;
  logic                tracing;

  verdict_t verdict_q [$];
  int       fail_cnt  = 0;
  int       hold_len  = 0;   // long receiver hold-off, picked up by the drain process
  bit       no_idle   = 1'b0;
  int       call_depth = 0;  // depth of the well-formed call stack being generated

  // Filter decision for one event; updates the predictor state
  function automatic verdict_t filter_event(input trace_evt_t e);
    int unsigned slot;
    marks_t      m;
    verdict_t    v;
    bit          skip;
    slot = e.level % STACK_LEVELS;
    v    = '0;
    if (e.cmd == CMD_ENTRY) begin
      lvl_saved[slot] = budget;
      m    = '0;
      skip = 1'b0;
      if (excl_open != 0) begin
        m.never_record = 1'b1;
        skip = 1'b1;
      end else if (e.filter_hit && !e.filter_exclude) begin
        if (incl_open != COUNT_MAX) incl_open = incl_open + 1'b1;
        m.filtered = 1'b1;
        budget = cfg_budget;
      end else if (e.filter_hit) begin
        if (excl_open != COUNT_MAX) excl_open = excl_open + 1'b1;
        m.notrace      = 1'b1;
        m.never_record = 1'b1;
        skip = 1'b1;
      end else if (cfg_incl_mode && incl_open == 0) begin
        m.never_record = 1'b1;
        skip = 1'b1;
      end
      if (!skip) begin
        if (e.depth_trigger) budget = e.trigger_depth;
        if (e.trace_on) tracing = 1'b1;
        if (e.trace_off) tracing = 1'b0;
        if (tracing) begin
          if (budget == 0) begin
            m.never_record = 1'b1;
          end else begin
            budget = budget - 1'b1;
            v.emit = 1'b1;
          end
        end
      end
      lvl_mark[slot] = m;
      v.no_record    = m.never_record;
    end else begin
      m = lvl_mark[slot];
      v.no_record = m.never_record;
      if (m.filtered) begin
        if (incl_open != 0) incl_open = incl_open - 1'b1;
      end else if (m.notrace) begin
        if (excl_open != 0) excl_open = excl_open - 1'b1;
      end
      lvl_mark[slot] = '0;
      budget = lvl_saved[slot];
    end
    v.depth_left = budget;
    return v;
  endfunction

  // Predict on every accepted input transaction
  always @(posedge clk) begin
    if (!rst && push && !full) begin
      verdict_q.push_back(filter_event(trace_evt));
    end
  end

  // Check every accepted result transaction against the oldest prediction
  always @(posedge clk) begin
    verdict_t want;
    if (!rst && pop && !empty) begin
      if (verdict_q.size() == 0) begin
        $error("verdict with no pending event: emit=%0d no_record=%0d depth_left=%0d",
               verdict.emit, verdict.no_record, verdict.depth_left);
        fail_cnt++;
      end else begin
        want = verdict_q.pop_front();
        if (verdict.emit !== want.emit) begin
          $error("emit mismatch: expected %0d, actual %0d", want.emit, verdict.emit);
          fail_cnt++;
        end
        if (verdict.no_record !== want.no_record) begin
          $error("no_record mismatch: expected %0d, actual %0d",
                 want.no_record, verdict.no_record);
          fail_cnt++;
        end
        if (verdict.depth_left !== want.depth_left) begin
          $error("depth_left mismatch: expected %0d, actual %0d",
                 want.depth_left, verdict.depth_left);
          fail_cnt++;
        end
      end
    end
  end

  // Result side: random stall per transaction, plus an occasional long hold-off
  initial begin
    int stall;
    pop = 1'b0;
    @(negedge clk);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 3);
      stall = stall + hold_len;
      hold_len = 0;
      if (stall > 0) begin
        pop <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty);
      @(negedge clk);
    end
  end

  // Send one event; returns at the edge where it is taken
  task automatic send_evt(input trace_evt_t e);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    @(negedge clk);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    push      <= 1'b1;
    trace_evt <= e;
    do @(posedge clk); while (full);
  endtask

  // Stop sending and wait for every prediction to be matched
  task automatic wait_idle();
    @(negedge clk);
    push <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Write both registers; called at a falling edge with the block idle
  task automatic write_config(input logic [BUDGET_W-1:0] dflt, input logic mode);
    cfg_write <= 1'b1;
    cfg_index <= REG_DEFAULT_BUDGET;
    cfg_data  <= dflt;
    @(posedge clk);
    cfg_budget = dflt;
    @(negedge clk);
    cfg_index <= REG_INCLUDE_MODE;
    cfg_data  <= CFG_DATA_W'(mode);
    @(posedge clk);
    cfg_incl_mode = mode;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  function automatic trace_evt_t entry_evt(input int unsigned lvl, input bit hit, input bit excl,
                                           input bit trig, input int unsigned tdepth,
                                           input bit on, input bit off);
    trace_evt_t e;
    e = '0;
    e.cmd            = CMD_ENTRY;
    e.level          = LEVEL_IN_W'(lvl);
    e.filter_hit     = hit;
    e.filter_exclude = excl;
    e.depth_trigger  = trig;
    e.trigger_depth  = BUDGET_W'(tdepth);
    e.trace_on       = on;
    e.trace_off      = off;
    return e;
  endfunction

  function automatic trace_evt_t exit_evt(input int unsigned lvl);
    trace_evt_t e;
    e = '0;
    e.cmd   = CMD_EXIT;
    e.level = LEVEL_IN_W'(lvl);
    return e;
  endfunction

  // Random event: mostly a well-formed call/return walk, some raw noise
  function automatic trace_evt_t rand_evt(input int max_depth);
    trace_evt_t  e;
    logic [31:0] raw;
    int          r;
    int unsigned td;
    r   = $urandom_range(0, 99);
    raw = $urandom;
    if (r < 12) begin
      e = raw[$bits(trace_evt_t)-1:0];
    end else if (call_depth == 0 || (call_depth < max_depth && r < 57)) begin
      td = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 3) : $urandom_range(0, 1023);
      e  = entry_evt(call_depth, $urandom_range(0, 99) < 20, $urandom_range(0, 2) == 0,
                     $urandom_range(0, 99) < 15, td,
                     $urandom_range(0, 99) < 10, $urandom_range(0, 99) < 7);
      call_depth++;
    end else begin
      e       = raw[$bits(trace_evt_t)-1:0];   // exit ignores the trigger fields
      e.cmd   = CMD_EXIT;
      e.level = LEVEL_IN_W'(call_depth - 1);
      call_depth--;
    end
    return e;
  endfunction

  task automatic unwind_calls();
    while (call_depth > 0) begin
      call_depth--;
      send_evt(exit_evt(call_depth));
    end
  endtask

  // Extremes of the fields and the named corner cases
  task automatic test_directed();
    send_evt(entry_evt(0, 0, 0, 0, 0, 0, 0));
    send_evt(entry_evt(1, 0, 1, 0, 0, 1, 0));      // kind bit without hit is ignored
    send_evt(entry_evt(2, 0, 0, 1, 0, 0, 0));      // trigger loads a zero budget
    send_evt(entry_evt(3, 0, 0, 0, 0, 0, 0));      // budget exhausted
    send_evt(exit_evt(3));
    send_evt(exit_evt(2));
    send_evt(entry_evt(2, 0, 0, 0, 0, 1, 1));      // off wins over on
    send_evt(entry_evt(3, 0, 0, 1, 1023, 1, 0));
    send_evt(exit_evt(3));
    send_evt(exit_evt(2));
    send_evt(entry_evt(2, 1, 0, 1, 5, 0, 0));      // include hit, then trigger
    send_evt(entry_evt(3, 1, 1, 0, 0, 0, 0));      // exclude hit
    send_evt(entry_evt(4, 1, 0, 0, 0, 0, 0));      // under an open exclude
    send_evt(exit_evt(4));
    send_evt(exit_evt(3));
    send_evt(exit_evt(2));
    send_evt(exit_evt(2));                         // unbalanced exit
    send_evt(exit_evt(600));                       // exit with no entry
    send_evt('1);                                  // all ones: exit at top level
    send_evt(entry_evt(1023, 1, 1, 1, 1023, 1, 1));
    send_evt(exit_evt(1023));
    send_evt(exit_evt(1));
    send_evt(exit_evt(0));
    wait_idle();
  endtask

  // Include mode with budget extremes, and a budget rewrite mid-stack
  task automatic test_config_extremes();
    write_config(0, 1'b1);
    send_evt(entry_evt(0, 0, 0, 0, 0, 1, 0));      // outside any include filter
    send_evt(exit_evt(0));
    send_evt(entry_evt(0, 1, 0, 0, 0, 0, 0));      // include restores a zero budget
    send_evt(entry_evt(1, 0, 0, 0, 0, 0, 0));
    send_evt(exit_evt(1));
    send_evt(exit_evt(0));
    wait_idle();
    write_config(1023, 1'b1);
    send_evt(entry_evt(0, 1, 0, 0, 0, 0, 0));
    wait_idle();
    write_config(7, 1'b1);                         // current budget must not move
    send_evt(entry_evt(1, 0, 0, 0, 0, 0, 0));
    send_evt(entry_evt(2, 1, 0, 0, 0, 0, 0));
    send_evt(exit_evt(2));
    send_evt(exit_evt(1));
    send_evt(exit_evt(0));
    wait_idle();
  endtask

  task automatic test_random(input logic [BUDGET_W-1:0] dflt, input logic mode,
                             input int n, input int max_depth);
    write_config(dflt, mode);
    for (int i = 0; i < n; i++) begin
      no_idle = (i % 100) >= 80;    // a stretch without idling every hundred items
      send_evt(rand_evt(max_depth));
    end
    no_idle = 1'b0;
    unwind_calls();
    wait_idle();
  endtask

  // Receiver holds off while the sender keeps offering, so full must rise
  task automatic test_backpressure();
    hold_len = 60;
    no_idle  = 1'b1;
    for (int i = 0; i < 24; i++) send_evt(rand_evt(40));
    no_idle = 1'b0;
    unwind_calls();
    wait_idle();
  endtask

  initial begin
    rst       = 1'b1;
    push      = 1'b0;
    trace_evt = '0;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;

    cfg_budget    = BUDGET_RESET;
    cfg_incl_mode = 1'b0;
    for (int i = 0; i < STACK_LEVELS; i++) begin
      lvl_mark[i]  = '0;
      lvl_saved[i] = BUDGET_RESET;
    end
    incl_open = '0;
    excl_open = '0;
    budget    = BUDGET_RESET;
    tracing   = 1'b1;

    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_directed();
    test_config_extremes();
    test_random(1023, 1'b0, 150, 60);
    test_random(3, 1'b1, 140, 30);
    test_random(BUDGET_W'($urandom_range(1, 1022)), 1'b1, 140, 60);
    test_random(BUDGET_W'($urandom_range(0, 8)), 1'b0, 150, 20);
    test_backpressure();

    if (fail_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// ===== sim.f =====
sv/cdtf_pkg.sv
sv/cdtf_ram.sv
sv/cdtf_front.sv
sv/cdtf_back.sv
sv/cdtf_outq.sv
sv/call_depth_trace_filter_unit.sv
verif/tb.sv
